FILE: sv/h2r_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// h2r_pkg
// Shared types and constants for the HSL to RGB converter pipeline.
// ---------------------------------------------------------------------------
package h2r_pkg;

    localparam int HUE_W     = 11;
    localparam int FRAC_W    = 13;
    localparam int BYTE_W    = 8;
    localparam int RAMP_W    = 9;
    localparam int TERM_W    = 25;  // Q24, 0..2^24
    localparam int VALUE_W   = 33;  // Q32, 0..2^32
    localparam int NUM_STAGES = 6;

    localparam logic [HUE_W-1:0]  HUE_TURN  = HUE_W'(1536);
    localparam logic [HUE_W-1:0]  HUE_SIXTH = HUE_W'(256);
    localparam logic [HUE_W-1:0]  HUE_THIRD = HUE_W'(512);
    localparam logic [FRAC_W-1:0] UNIT_Q12  = FRAC_W'(4096);
    localparam logic [FRAC_W-1:0] HALF_Q12  = FRAC_W'(2048);

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] saturation;
        logic [FRAC_W-1:0] lightness;
    } hsl_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [FRAC_W-1:0] saturation;
        logic [FRAC_W-1:0] lightness;
    } sl_t;

    // Per-pixel data that bypasses the term and channel math.
    typedef struct packed {
        logic              grey;
        logic [BYTE_W-1:0] grey_level;
        logic [RAMP_W-1:0] t_red;
        logic [RAMP_W-1:0] t_green;
        logic [RAMP_W-1:0] t_blue;
    } side_t;

    // Clock enables of a two-stage section.
    typedef struct packed {
        logic first;
        logic second;
    } en2_t;

endpackage

`default_nettype wire

FILE: sv/h2r_prep.sv
`default_nettype none
// ---------------------------------------------------------------------------
// h2r_prep
// Stage 1: wraps hue, clamps S and L, forms grey level and hue ramps.
// ---------------------------------------------------------------------------
module h2r_prep (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire h2r_pkg::hsl_t  pixel,
    output h2r_pkg::sl_t        sl_reg,
    output h2r_pkg::side_t      side_reg
);

    function automatic logic [h2r_pkg::RAMP_W-1:0] hue_ramp(
        input logic [h2r_pkg::HUE_W-1:0] x
    );
        logic [h2r_pkg::HUE_W-1:0] down;
        down = (h2r_pkg::HUE_W'(4) * h2r_pkg::HUE_SIXTH) - x;
        if (x < h2r_pkg::HUE_SIXTH) begin
            return x[h2r_pkg::RAMP_W-1:0];
        end else if (x < h2r_pkg::HUE_W'(3) * h2r_pkg::HUE_SIXTH) begin
            return h2r_pkg::RAMP_W'(h2r_pkg::HUE_SIXTH);
        end else if (x < h2r_pkg::HUE_W'(4) * h2r_pkg::HUE_SIXTH) begin
            return down[h2r_pkg::RAMP_W-1:0];
        end else begin
            return '0;
        end
    endfunction

    logic [h2r_pkg::HUE_W-1:0]    hue_w;
    logic [h2r_pkg::HUE_W:0]      hue_up;
    logic [h2r_pkg::HUE_W-1:0]    hue_red;
    logic [h2r_pkg::HUE_W-1:0]    hue_blue;
    logic [h2r_pkg::FRAC_W-1:0]   sat_c;
    logic [h2r_pkg::FRAC_W-1:0]   lit_c;
    logic [h2r_pkg::FRAC_W+7:0]   grey_prod;
    h2r_pkg::sl_t                 sl_next;
    h2r_pkg::side_t               side_next;

    always_comb begin
        hue_w = (pixel.hue >= h2r_pkg::HUE_TURN) ? pixel.hue - h2r_pkg::HUE_TURN
                                                 : pixel.hue;
        sat_c = (pixel.saturation > h2r_pkg::UNIT_Q12) ? h2r_pkg::UNIT_Q12
                                                       : pixel.saturation;
        lit_c = (pixel.lightness > h2r_pkg::UNIT_Q12) ? h2r_pkg::UNIT_Q12
                                                      : pixel.lightness;

        hue_up  = {1'b0, hue_w} + {1'b0, h2r_pkg::HUE_THIRD};
        hue_red = (hue_up > {1'b0, h2r_pkg::HUE_TURN})
                  ? h2r_pkg::HUE_W'(hue_up - {1'b0, h2r_pkg::HUE_TURN})
                  : hue_up[h2r_pkg::HUE_W-1:0];
        hue_blue = (hue_w < h2r_pkg::HUE_THIRD)
                   ? hue_w + (h2r_pkg::HUE_TURN - h2r_pkg::HUE_THIRD)
                   : hue_w - h2r_pkg::HUE_THIRD;

        // 255 * L = 256 * L - L
        grey_prod = {lit_c, 8'd0} - {8'd0, lit_c};

        sl_next.saturation   = sat_c;
        sl_next.lightness    = lit_c;
        side_next.grey       = (sat_c == '0);
        side_next.grey_level = grey_prod[h2r_pkg::FRAC_W+6 -: h2r_pkg::BYTE_W];
        side_next.t_red      = hue_ramp(hue_red);
        side_next.t_green    = hue_ramp(hue_w);
        side_next.t_blue     = hue_ramp(hue_blue);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sl_reg   <= sl_next;
            side_reg <= side_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/h2r_terms.sv
`default_nettype none
// ---------------------------------------------------------------------------
// h2r_terms
// Stages 2-3: S*L product, then the low term Q and the span P - Q in Q24.
// ---------------------------------------------------------------------------
module h2r_terms (
    input  wire logic                           aclk,
    input  wire h2r_pkg::en2_t                  en,
    input  wire h2r_pkg::sl_t                   sl,
    output logic [h2r_pkg::TERM_W-1:0]          lo_reg,
    output logic [h2r_pkg::TERM_W-1:0]          span_reg
);

    localparam int W = h2r_pkg::TERM_W;
    localparam int F = h2r_pkg::FRAC_W;

    logic [2*F-1:0]  prod_full;
    logic [W-1:0]    prod_reg;
    logic [W-1:0]    prod_next;
    h2r_pkg::sl_t    sl_reg;
    logic            upper_reg;
    logic [W+1:0]    l_q24;
    logic [W+1:0]    s_q24;
    logic [W+1:0]    lo_wide;
    logic [W+1:0]    span_wide;
    logic [W-1:0]    lo_next;
    logic [W-1:0]    span_next;

    always_comb begin
        prod_full = sl.saturation * sl.lightness;
        prod_next = prod_full[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en.first) begin
            prod_reg  <= prod_next;
            sl_reg    <= sl;
            upper_reg <= (sl.lightness >= h2r_pkg::HALF_Q12);
        end
    end

    // L < 1/2 : Q = L - S*L,        P - Q = 2*S*L
    // else    : Q = L - S + S*L,    P - Q = 2*(S - S*L)
    always_comb begin
        l_q24 = {2'b00, sl_reg.lightness, 12'd0};
        s_q24 = {2'b00, sl_reg.saturation, 12'd0};
        if (upper_reg) begin
            lo_wide   = l_q24 + {2'b00, prod_reg} - s_q24;
            span_wide = (s_q24 - {2'b00, prod_reg}) << 1;
        end else begin
            lo_wide   = l_q24 - {2'b00, prod_reg};
            span_wide = {1'b0, prod_reg, 1'b0};
        end
        lo_next   = lo_wide[W-1:0];
        span_next = span_wide[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en.second) begin
            lo_reg   <= lo_next;
            span_reg <= span_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/h2r_channel.sv
`default_nettype none
// ---------------------------------------------------------------------------
// h2r_channel
// Stages 4-5: one channel value Q*256 + (P - Q)*t in Q32.
// ---------------------------------------------------------------------------
module h2r_channel (
    input  wire logic                           aclk,
    input  wire h2r_pkg::en2_t                  en,
    input  wire logic [h2r_pkg::TERM_W-1:0]     lo,
    input  wire logic [h2r_pkg::TERM_W-1:0]     span,
    input  wire logic [h2r_pkg::RAMP_W-1:0]     ramp,
    output logic [h2r_pkg::VALUE_W-1:0]         value_reg
);

    localparam int W = h2r_pkg::TERM_W;
    localparam int V = h2r_pkg::VALUE_W;

    logic [W+h2r_pkg::RAMP_W-1:0] mul_full;
    logic [V-1:0]                 mul_reg;
    logic [W-1:0]                 lo_reg;
    logic [V:0]                   sum_wide;
    logic [V-1:0]                 value_next;

    assign mul_full = span * ramp;

    always_ff @(posedge aclk) begin
        if (en.first) begin
            mul_reg <= mul_full[V-1:0];
            lo_reg  <= lo;
        end
    end

    always_comb begin
        sum_wide   = {1'b0, lo_reg, 8'd0} + {1'b0, mul_reg};
        value_next = sum_wide[V-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en.second) begin
            value_reg <= value_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/hsl_to_rgb_converter_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hsl_to_rgb_converter_top
// HSL pixel (hue 1536/turn, S and L in Q12) to 8-bit RGB, six-stage pipeline.
// ---------------------------------------------------------------------------
//  channel   direction  payload           handshake
//  s_*       in         hsl_t  (h, s, l)  s_valid / s_ready
//  m_*       out        rgb_t  (r, g, b)  m_valid / m_ready
//
//  One pixel per clock sustained while m_ready is high; each pixel passes
//  through stage registers 1 to 6 in order before m_valid rises for it.
//  Depth: the prep stage, the S*L multiplier, the Q and P-Q terms, the
//  per-channel (P-Q)*t multiplier, the Q32 add and the x255 scale stages.
//  aresetn (synchronous) clears all stage valid bits; payload is not reset.
//  Each stage holds when the stage after it is full and stalled, so empty
//  stages still fill while m_ready is low.
// ---------------------------------------------------------------------------
module hsl_to_rgb_converter_top (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire h2r_pkg::hsl_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output h2r_pkg::rgb_t       m_data
);

    localparam int N = h2r_pkg::NUM_STAGES;
    localparam int V = h2r_pkg::VALUE_W;

    function automatic logic [h2r_pkg::BYTE_W-1:0] scale_byte(
        input logic [V-1:0] value
    );
        logic [V+7:0] prod;
        prod = {value, 8'd0} - {8'd0, value};
        if (prod[V+7]) begin
            return '1;
        end else begin
            return prod[V+6 -: h2r_pkg::BYTE_W];
        end
    endfunction

    logic [N:1]            valid_reg;
    logic [N:1]            valid_next;
    logic [N:1]            stage_en;
    logic [N:1]            upstream;

    h2r_pkg::sl_t          sl_s1;
    h2r_pkg::side_t        side_s1;
    h2r_pkg::side_t        side_s2_reg;
    h2r_pkg::side_t        side_s3_reg;
    h2r_pkg::side_t        side_s4_reg;
    h2r_pkg::side_t        side_s5_reg;
    logic [h2r_pkg::TERM_W-1:0] lo_s3;
    logic [h2r_pkg::TERM_W-1:0] span_s3;
    logic [V-1:0]          value_red;
    logic [V-1:0]          value_green;
    logic [V-1:0]          value_blue;
    h2r_pkg::en2_t         en_terms;
    h2r_pkg::en2_t         en_chan;
    h2r_pkg::rgb_t         m_data_reg;
    h2r_pkg::rgb_t         m_data_next;
    logic                  grey6_reg;

    // ---- stage control ----
    always_comb begin
        stage_en[N] = !valid_reg[N] || m_ready;
        for (int k = N - 1; k >= 1; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        upstream   = {valid_reg[N-1:1], s_valid};
        valid_next = valid_reg;
        for (int k = 1; k <= N; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = upstream[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[1];
    assign m_valid = valid_reg[N];
    assign m_data  = m_data_reg;

    assign en_terms = '{first: stage_en[2], second: stage_en[3]};
    assign en_chan  = '{first: stage_en[4], second: stage_en[5]};

    // ---- datapath ----
    h2r_prep u_prep (
        .aclk     (aclk),
        .en       (stage_en[1]),
        .pixel    (s_data),
        .sl_reg   (sl_s1),
        .side_reg (side_s1)
    );

    h2r_terms u_terms (
        .aclk     (aclk),
        .en       (en_terms),
        .sl       (sl_s1),
        .lo_reg   (lo_s3),
        .span_reg (span_s3)
    );

    h2r_channel u_red (
        .aclk      (aclk),
        .en        (en_chan),
        .lo        (lo_s3),
        .span      (span_s3),
        .ramp      (side_s3_reg.t_red),
        .value_reg (value_red)
    );

    h2r_channel u_green (
        .aclk      (aclk),
        .en        (en_chan),
        .lo        (lo_s3),
        .span      (span_s3),
        .ramp      (side_s3_reg.t_green),
        .value_reg (value_green)
    );

    h2r_channel u_blue (
        .aclk      (aclk),
        .en        (en_chan),
        .lo        (lo_s3),
        .span      (span_s3),
        .ramp      (side_s3_reg.t_blue),
        .value_reg (value_blue)
    );

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            side_s2_reg <= side_s1;
        end
        if (stage_en[3]) begin
            side_s3_reg <= side_s2_reg;
        end
        if (stage_en[4]) begin
            side_s4_reg <= side_s3_reg;
        end
        if (stage_en[5]) begin
            side_s5_reg <= side_s4_reg;
        end
    end

    // ---- output register: x255 scale or grey ----
    always_comb begin
        if (side_s5_reg.grey) begin
            m_data_next.red   = side_s5_reg.grey_level;
            m_data_next.green = side_s5_reg.grey_level;
            m_data_next.blue  = side_s5_reg.grey_level;
        end else begin
            m_data_next.red   = scale_byte(value_red);
            m_data_next.green = scale_byte(value_green);
            m_data_next.blue  = scale_byte(value_blue);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[N]) begin
            m_data_reg <= m_data_next;
            grey6_reg  <= side_s5_reg.grey;
        end
    end

    // ---- assertions ----
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == !((&valid_reg) && !m_ready))
        else $error("s_ready does not match pipeline occupancy");

    a_hold_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&valid_reg) && !m_ready) |=> $stable(valid_reg))
        else $error("pipeline moved while full and stalled");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[1])
        else $error("accepted request not captured in first stage");

    a_grey_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && grey6_reg) |->
            (m_data.red == m_data.green) && (m_data.green == m_data.blue))
        else $error("grey pixel has unequal channels");

endmodule

`default_nettype wire
